// ----- hw/rtl/bsc_pkg.sv -----
// shared types, widths and arithmetic helpers for the barometer compensation block
// no dependencies
package bsc_pkg;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned CAL_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned READ_W  = 22;
  localparam int unsigned DT_W    = 26;
  localparam int unsigned MUL_B_W = RAW_W + 1;
  localparam int unsigned PROD_W  = DT_W + MUL_B_W;
  localparam int unsigned TERM_W  = 36;
  localparam int unsigned WIDE_W  = 60;
  localparam int unsigned SPLIT_W = 18;

  localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  localparam logic signed [WIDE_W-1:0] TEMP_BASE = WIDE_W'(2000);
  localparam logic signed [WIDE_W-1:0] READ_MAX  = WIDE_W'(2097151);
  localparam logic signed [WIDE_W-1:0] READ_MIN  = WIDE_W'(-2097152);

  // signed divide by 2^k, rounding toward zero
  function automatic logic signed [WIDE_W-1:0] trunc_div(input logic signed [WIDE_W-1:0] x,
                                                         input int unsigned k);
    logic signed [WIDE_W-1:0] bias;
    bias = x[WIDE_W-1] ? $signed(WIDE_W'((64'd1 << k) - 64'd1)) : '0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [READ_W-1:0] clamp_reading(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (c > READ_MAX) c = READ_MAX;
    if (c < READ_MIN) c = READ_MIN;
    return c[READ_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/bsc_if.sv -----
// request channels of the barometer compensation block: sample in, result out, config write
// depends on bsc_pkg
interface bsc_in_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [RAW_W-1:0] raw_sample;
  modport source (output valid, output mode, output raw_sample, input ready);
  modport sink   (input valid, input mode, input raw_sample, output ready);
endinterface

interface bsc_out_if import bsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [READ_W-1:0] reading;
  modport source (output valid, output kind, output reading, input ready);
  modport sink   (input valid, input kind, input reading, output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CAL_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/baro_sensor_compensation.sv -----
// barometer first-order compensation: sequencer around one shared multiplier
// depends on bsc_pkg and bsc_if
//
// usage:
//   sample_i carries raw 24-bit conversions tagged temperature (mode 0) or pressure (mode 1).
//   result_o returns one reading per request: kind equals mode, reading is signed 22 bits,
//   0.01 degC or 0.01 mbar, saturated to its range.
//   cfg_i writes the six calibration words, index 0..5; other indexes are dropped.
//   cfg_i is always ready; write it only while the block is idle.
// sequence:
//   a temperature request steps through ST_T_MUL and ST_T_FIN, a pressure request through
//   ST_P_OFF to ST_P_FIN. one request is in flight at a time; sample_i.ready is high only
//   in the idle state. the steps follow the passes through the single 26x25 multiplier,
//   which is registered, plus the truncating add and subtract steps of the pressure path.
// reset:
//   calibration words and the stored temperature difference clear to zero; a pressure
//   request before any temperature request uses a difference of zero.
// stall:
//   the result register holds while result_o.ready is low; a finished computation waits
//   in its last step until the result register is free, and then the block is ready again.
module baro_sensor_compensation import bsc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  bsc_in_if.sink         sample_i,
  bsc_out_if.source      result_o,
  bsc_cfg_if.sink        cfg_i
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_T_MUL  = 11'b000_0000_0010,
    ST_T_FIN  = 11'b000_0000_0100,
    ST_P_OFF  = 11'b000_0000_1000,
    ST_P_SENS = 11'b000_0001_0000,
    ST_P_SCL  = 11'b000_0010_0000,
    ST_P_LO   = 11'b000_0100_0000,
    ST_P_HI   = 11'b000_1000_0000,
    ST_P_ACC  = 11'b001_0000_0000,
    ST_P_SUB  = 11'b010_0000_0000,
    ST_P_FIN  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic signed [DT_W-1:0]   dt_q;
  logic [RAW_W-1:0]         raw_q;
  logic                     mode_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] off_q, off_d;
  logic signed [TERM_W-1:0] sens_q, sens_d;
  logic signed [WIDE_W-1:0] acc_q, acc_d;
  logic                     out_valid_q;
  logic                     out_kind_q;
  logic signed [READ_W-1:0] out_reading_q, out_reading_d;

  logic signed [DT_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [WIDE_W-1:0]  prod_ext;
  logic signed [WIDE_W-1:0]  off_ext;
  logic signed [DT_W-1:0]    dt_new;
  logic                      in_fire;
  logic                      fin_ok;
  logic                      out_load;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign cfg_i.ready    = 1'b1;
  assign fin_ok         = !out_valid_q || result_o.ready;

  assign result_o.valid   = out_valid_q;
  assign result_o.kind    = out_kind_q;
  assign result_o.reading = out_reading_q;

  assign dt_new = $signed({2'b00, sample_i.raw_sample}) - $signed({2'b00, c5_q, 8'h00});

  assign prod_ext = $signed({{(WIDE_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
  assign off_ext  = $signed({{(WIDE_W-TERM_W){off_q[TERM_W-1]}}, off_q});

  // shared multiplier operand select
  always_comb begin
    mul_a = dt_q;
    mul_b = '0;
    case (state_q)
      ST_T_MUL, ST_T_FIN: mul_b = $signed({{(MUL_B_W-CAL_W){1'b0}}, c6_q});
      ST_P_OFF:  mul_b = $signed({{(MUL_B_W-CAL_W){1'b0}}, c4_q});
      ST_P_SENS: mul_b = $signed({{(MUL_B_W-CAL_W){1'b0}}, c3_q});
      ST_P_LO: begin
        mul_a = $signed({{(DT_W-SPLIT_W){1'b0}}, sens_q[SPLIT_W-1:0]});
        mul_b = $signed({1'b0, raw_q});
      end
      ST_P_HI: begin
        mul_a = $signed({{(DT_W-(TERM_W-SPLIT_W)){sens_q[TERM_W-1]}},
                         sens_q[TERM_W-1:SPLIT_W]});
        mul_b = $signed({1'b0, raw_q});
      end
      default: begin
        mul_a = dt_q;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    logic signed [WIDE_W-1:0] sum;
    state_d       = state_q;
    off_d         = off_q;
    sens_d        = sens_q;
    acc_d         = acc_q;
    out_reading_d = out_reading_q;
    out_load      = 1'b0;
    sum           = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = (sample_i.mode == MODE_PRESS) ? ST_P_OFF : ST_T_MUL;
      end
      ST_T_MUL:  state_d = ST_T_FIN;
      ST_T_FIN: begin
        sum = TEMP_BASE + trunc_div(prod_ext, 23);
        if (fin_ok) begin
          out_reading_d = clamp_reading(sum);
          out_load      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_P_OFF:  state_d = ST_P_SENS;
      ST_P_SENS: begin
        sum     = $signed({{(WIDE_W-CAL_W-16){1'b0}}, c2_q, 16'h0000}) + trunc_div(prod_ext, 7);
        off_d   = sum[TERM_W-1:0];
        state_d = ST_P_SCL;
      end
      ST_P_SCL: begin
        sum     = $signed({{(WIDE_W-CAL_W-15){1'b0}}, c1_q, 15'h0000}) + trunc_div(prod_ext, 8);
        sens_d  = sum[TERM_W-1:0];
        state_d = ST_P_LO;
      end
      ST_P_LO:   state_d = ST_P_HI;
      ST_P_HI: begin
        acc_d   = prod_ext;
        state_d = ST_P_ACC;
      end
      ST_P_ACC: begin
        acc_d   = acc_q + (prod_ext <<< SPLIT_W);
        state_d = ST_P_SUB;
      end
      ST_P_SUB: begin
        acc_d   = trunc_div(acc_q, 21) - off_ext;
        state_d = ST_P_FIN;
      end
      ST_P_FIN: begin
        if (fin_ok) begin
          out_reading_d = clamp_reading(trunc_div(acc_q, 15));
          out_load      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dt_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      c3_q        <= '0;
      c4_q        <= '0;
      c5_q        <= '0;
      c6_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && sample_i.mode == MODE_TEMP) dt_q <= dt_new;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_C1:  c1_q <= cfg_i.data;
          REG_C2:  c2_q <= cfg_i.data;
          REG_C3:  c3_q <= cfg_i.data;
          REG_C4:  c4_q <= cfg_i.data;
          REG_C5:  c5_q <= cfg_i.data;
          REG_C6:  c6_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    prod_q        <= prod_d;
    off_q         <= off_d;
    sens_q        <= sens_d;
    acc_q         <= acc_d;
    out_reading_q <= out_reading_d;
    if (in_fire) begin
      raw_q  <= sample_i.raw_sample;
      mode_q <= sample_i.mode;
    end
    if (out_load) out_kind_q <= mode_q;
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_T_FIN || state_q == ST_P_FIN))
    else $error("result loaded outside a final step");

  a_kind_matches_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_kind_q == ($past(state_q) == ST_P_FIN)))
    else $error("result kind does not match the computation path");

  a_dt_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(dt_q) |-> $past(in_fire && sample_i.mode == MODE_TEMP))
    else $error("temperature difference changed without a temperature request");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule
